// File: rtl/phe_pkg.sv
// Shared constants and types of the Horner polynomial evaluator.
package phe_pkg;

    localparam int DATA_W       = 32;
    localparam int FRAC_BITS    = 24;
    localparam int MAX_DEGREE   = 6;
    localparam int NUM_COEFS    = MAX_DEGREE + 1;
    localparam int DEG_W        = 3;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int QUEUE_CNT_W  = 2;
    localparam int PIPE_LATENCY = 2 * MAX_DEGREE + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEGREE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COEF0  = CFG_IDX_W'(1);

    typedef logic [DATA_W-1:0]       word_t;
    typedef logic [DEG_W-1:0]        deg_t;
    typedef word_t [NUM_COEFS-1:0]   coef_vec_t;

    localparam word_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [QUEUE_CNT_W-1:0] QUEUE_DEPTH = QUEUE_CNT_W'(2);

    // One sample on its way from the front to the Horner pipeline.
    typedef struct packed {
        word_t x;
        word_t acc;
        deg_t  deg;
    } job_t;

endpackage

// File: rtl/phe_front.sv
// Front part: configuration registers, sample acceptance and job setup.
module phe_front
    import phe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [DATA_W-1:0] x_value,
    output logic                  busy,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_full,
    output logic                  push,
    output job_t                  push_job,
    output coef_vec_t             coefs
);

    deg_t      degree_reg;
    coef_vec_t coef_reg;
    deg_t      deg_eff;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;
    assign push      = start & ~q_full;
    assign coefs     = coef_reg;

    // Degrees above the supported maximum behave as the maximum.
    assign deg_eff = (degree_reg > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_reg;

    // The accumulator starts at the leading coefficient.
    always_comb
    begin
        push_job.x   = word_t'(x_value);
        push_job.acc = coef_reg[deg_eff];
        push_job.deg = deg_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= '0;
            coef_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_IDX_DEGREE)
            begin
                degree_reg <= cfg_data[DEG_W-1:0];
            end
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                if (cfg_index == CFG_IDX_COEF0 + CFG_IDX_W'(i))
                begin
                    coef_reg[i] <= cfg_data[DATA_W-1:0];
                end
            end
        end
    end

endmodule

// File: rtl/phe_queue.sv
// Two-entry job queue between the front and the Horner pipeline.
module phe_queue
    import phe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    job_t                   mem_reg [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    // The pipeline behind never stalls, so the head leaves whenever it is valid.
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QUEUE_DEPTH);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign count_next = count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(head_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (head_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/phe_back.sv
// Back part: one two-register Horner stage per possible coefficient step.
module phe_back
    import phe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_valid,
    input  job_t                     head_job,
    input  coef_vec_t                coefs,
    output logic                     done,
    output logic signed [DATA_W-1:0] y_value,
    output logic                     overflow
);

    // Index j is the input of stage j; index MAX_DEGREE is the pipeline output.
    logic  st_valid [MAX_DEGREE+1];
    word_t st_acc   [MAX_DEGREE+1];
    logic  st_ovf   [MAX_DEGREE+1];
    word_t st_x     [MAX_DEGREE];
    deg_t  st_deg   [MAX_DEGREE];

    assign st_valid[0] = head_valid;
    assign st_acc[0]   = head_job.acc;
    assign st_ovf[0]   = 1'b0;
    assign st_x[0]     = head_job.x;
    assign st_deg[0]   = head_job.deg;

    for (genvar j = 0; j < MAX_DEGREE; j++)
    begin : g_stage
        // Stage j adds coefficient MAX_DEGREE-1-j; lower degrees skip early stages.
        localparam int CI = MAX_DEGREE - 1 - j;

        logic                     a_valid_reg;
        logic                     a_active_reg;
        logic                     a_ovf_reg;
        logic signed [PROD_W-1:0] a_prod_reg;
        word_t                    a_acc_reg;
        logic signed [PROD_W-1:0] a_prod_next;
        logic                     a_active_next;

        logic                     b_valid_reg;
        word_t                    b_acc_reg;
        logic                     b_ovf_reg;
        logic [PROD_W-FRAC_BITS-DATA_W:0] prod_hi;
        logic                     prod_fits;
        word_t                    prod_sat;
        word_t                    coef;
        logic [DATA_W:0]          sum;
        logic                     sum_fits;
        word_t                    sum_sat;
        word_t                    b_acc_next;
        logic                     b_ovf_next;

        assign a_prod_next   = $signed(st_acc[j]) * $signed(st_x[j]);
        assign a_active_next = (st_deg[j] > DEG_W'(CI));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_valid_reg <= 1'b0;
                b_valid_reg <= 1'b0;
            end
            else
            begin
                a_valid_reg <= st_valid[j];
                b_valid_reg <= a_valid_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            a_prod_reg   <= a_prod_next;
            a_active_reg <= a_active_next;
            a_ovf_reg    <= st_ovf[j];
            a_acc_reg    <= st_acc[j];
            b_acc_reg    <= b_acc_next;
            b_ovf_reg    <= b_ovf_next;
        end

        // Arithmetic shift keeps the product bits above the binary point;
        // the shifted value fits in 32 bits when its upper bits are all sign.
        assign prod_hi   = a_prod_reg[PROD_W-1:FRAC_BITS+DATA_W-1];
        assign prod_fits = (&prod_hi) | ~(|prod_hi);
        assign prod_sat  = prod_fits ? word_t'(a_prod_reg[FRAC_BITS+DATA_W-1:FRAC_BITS])
                                     : (a_prod_reg[PROD_W-1] ? Q_MIN : Q_MAX);

        assign coef     = coefs[CI];
        assign sum      = {prod_sat[DATA_W-1], prod_sat} + {coef[DATA_W-1], coef};
        assign sum_fits = (sum[DATA_W] == sum[DATA_W-1]);
        assign sum_sat  = sum_fits ? sum[DATA_W-1:0] : (sum[DATA_W] ? Q_MIN : Q_MAX);

        assign b_acc_next = a_active_reg ? sum_sat : a_acc_reg;
        assign b_ovf_next = a_ovf_reg | (a_active_reg & (~prod_fits | ~sum_fits));

        assign st_valid[j+1] = b_valid_reg;
        assign st_acc[j+1]   = b_acc_reg;
        assign st_ovf[j+1]   = b_ovf_reg;

        // The sample and its degree ride along from every stage but the last to the next one.
        if (j < MAX_DEGREE - 1)
        begin : g_carry
            word_t a_x_reg;
            deg_t  a_deg_reg;
            word_t b_x_reg;
            deg_t  b_deg_reg;

            always_ff @(posedge clk)
            begin
                a_x_reg   <= st_x[j];
                a_deg_reg <= st_deg[j];
                b_x_reg   <= a_x_reg;
                b_deg_reg <= a_deg_reg;
            end

            assign st_x[j+1]   = b_x_reg;
            assign st_deg[j+1] = b_deg_reg;
        end
    end

    assign done     = st_valid[MAX_DEGREE];
    assign y_value  = $signed(st_acc[MAX_DEGREE]);
    assign overflow = st_ovf[MAX_DEGREE];

endmodule

// File: rtl/polynomial_horner_eval_core.sv
// Top level of the Horner polynomial evaluator.
//
// The block evaluates c_d*x^d + ... + c_1*x + c_0 in signed Q8.24 for every
// sample x, using Horner's rule with truncating products and saturating steps.
// A sample transfer happens at a rising edge with start high and busy low; the
// sample sits on x_value in that cycle. Results come out in sample order: done
// is high for exactly one cycle with y_value and overflow valid, and the
// receiver must take them in that cycle because there is no way to hold them.
// A sample passes the job queue and then the six Horner stages, each a
// multiply register followed by a shift, saturate and add register. Lower
// degrees pass through the leading stages unchanged, so every sample takes the
// same path through the pipeline.
// A new sample may be transferred on every clock cycle; busy stays low in
// normal use because the pipeline behind the queue never stalls.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready: index 0 is the degree, indices 1 to 7 are coefficients 0 to 6,
// and other indices are ignored. Write it only while no sample is in flight.
// Reset clears the degree and all coefficients to zero and empties the pipeline.
module polynomial_horner_eval_core
    import phe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] x_value,
    output logic                     busy,
    output logic                     done,
    output logic signed [DATA_W-1:0] y_value,
    output logic                     overflow,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    logic      q_full;
    logic      push;
    job_t      push_job;
    logic      head_valid;
    job_t      head_job;
    coef_vec_t coefs;

    // The front holds the registers and turns a sample into a job that
    // carries the clamped degree and the leading coefficient.
    phe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .x_value   (x_value),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job),
        .coefs     (coefs)
    );

    // The queue decouples the front from the pipeline.
    phe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // The back runs the Horner steps, one stage per coefficient after the leading one.
    phe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .coefs      (coefs),
        .done       (done),
        .y_value    (y_value),
        .overflow   (overflow)
    );

endmodule

// File: rtl/phe_checker.sv
// Port-level checks of the Horner polynomial evaluator and their binding.
module phe_checker
    import phe_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_valid,
    input logic cfg_ready
);

    // Every transferred sample gives its result after the pipeline latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("sample transfer without result after pipeline latency");

    // No result appears without a sample transferred that long before.
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without matching sample transfer");

    // The pipeline never stalls, so the queue never fills up.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised although the pipeline drains every cycle");

    // Configuration writes are always taken.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write not taken");

endmodule

bind polynomial_horner_eval_core phe_checker u_phe_checker (.*);
